// ===== rtl/core/sfd_pkg.sv =====
// shared types and constants of the stuffed frame receive deframer
// no dependencies

package sfd_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int KIND_WIDTH  = 2;
   localparam int LEN_WIDTH   = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [BYTE_WIDTH-1:0] FLAG_BYTE = 8'h7e;
   localparam logic [BYTE_WIDTH-1:0] ESC_BYTE  = 8'h7d;
   localparam logic [BYTE_WIDTH-1:0] STUFF_FLAG_CODE = 8'h5e;
   localparam logic [BYTE_WIDTH-1:0] ESC_ESC   = 8'h5d;

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

   localparam logic [BYTE_WIDTH-1:0] ADDRESS_RESET  = 8'd3;
   localparam logic [BYTE_WIDTH-1:0] CTRL_ZERO_RESET = 8'd0;
   localparam logic [BYTE_WIDTH-1:0] CTRL_ONE_RESET  = 8'd64;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ADDRESS   = 2'd0,
      CSR_CTRL_ZERO = 2'd1,
      CSR_CTRL_ONE  = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_REJECT  = 2'd2,
      KIND_ESC_ERR = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      ST_WAIT = 6'b000001,
      ST_ADDR = 6'b000010,
      ST_CTRL = 6'b000100,
      ST_HCHK = 6'b001000,
      ST_DATA = 6'b010000,
      ST_ESC  = 6'b100000
   } hunt_type;

endpackage

// ===== rtl/core/sfd_if.sv =====
// request and response channel interfaces of the deframer
// depends on sfd_pkg

interface sfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfd_pkg::BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfd_pkg::KIND_WIDTH-1:0] result_kind;
   logic [sfd_pkg::BYTE_WIDTH-1:0] payload_byte;
   logic                          next_seq;
   logic [sfd_pkg::LEN_WIDTH-1:0]  frame_length;

   modport source (output valid, output result_kind, output payload_byte,
                   output next_seq, output frame_length, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input next_seq, input frame_length, output ready);
endinterface

// ===== rtl/core/stuffed_frame_receive_deframer_core.sv =====
// top level of the stuffed frame receive deframer: header hunt, destuffing,
// xor check and verdict; depends on sfd_pkg and sfd_if
//
// channel   dir  handshake        payload
// req_ch    in   valid / ready    rx_byte
// rsp_ch    out  valid / ready    result_kind, payload_byte, next_seq, frame_length
// csr_*     in   csr_write_en     csr_index, csr_wdata
//
// one byte per cycle sustained while rsp ready is high: a byte is registered, then the
// one-pass state update writes the result register once the input register advances
// the result register frees on rsp ready; the input register holds only while it stalls
// synchronous active-high reset returns the hunt to waiting for a flag and
// loads the register reset values

module stuffed_frame_receive_deframer_core (
   input  logic                              clock,
   input  logic                              reset,
   sfd_req_if.sink                           req_ch,
   sfd_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [sfd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [sfd_pkg::BYTE_WIDTH-1:0]    csr_wdata
);

   logic [sfd_pkg::BYTE_WIDTH-1:0] address_ff;
   logic [sfd_pkg::BYTE_WIDTH-1:0] ctrl_zero_ff;
   logic [sfd_pkg::BYTE_WIDTH-1:0] ctrl_one_ff;

   logic                           s1_valid_ff, s1_valid_in;
   logic [sfd_pkg::BYTE_WIDTH-1:0] s1_byte_ff;
   logic                           s1_advance;

   sfd_pkg::hunt_type              state_ff, state_in;
   logic [sfd_pkg::BYTE_WIDTH-1:0] control_ff, control_in;
   logic                           seq_ff, seq_in;
   logic [sfd_pkg::BYTE_WIDTH-1:0] held_ff, held_in;
   logic                           held_valid_ff, held_valid_in;
   logic [sfd_pkg::BYTE_WIDTH-1:0] xor_ff, xor_in;
   logic [sfd_pkg::COUNT_WIDTH-1:0] count_ff, count_in;

   logic                           res_valid;
   sfd_pkg::kind_type              res_kind;
   logic [sfd_pkg::BYTE_WIDTH-1:0] res_byte;
   logic                           res_seq;
   logic [sfd_pkg::LEN_WIDTH-1:0]  res_len;
   logic                           take;
   logic [sfd_pkg::BYTE_WIDTH-1:0] take_byte;
   logic [sfd_pkg::COUNT_WIDTH-1:0] len_full;
   logic                           load_out;

   logic                           out_valid_ff, out_valid_in;
   sfd_pkg::kind_type              out_kind_ff;
   logic [sfd_pkg::BYTE_WIDTH-1:0] out_byte_ff;
   logic                           out_seq_ff;
   logic [sfd_pkg::LEN_WIDTH-1:0]  out_len_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff   <= sfd_pkg::ADDRESS_RESET;
         ctrl_zero_ff <= sfd_pkg::CTRL_ZERO_RESET;
         ctrl_one_ff  <= sfd_pkg::CTRL_ONE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            sfd_pkg::CSR_ADDRESS:   address_ff   <= csr_wdata;
            sfd_pkg::CSR_CTRL_ZERO: ctrl_zero_ff <= csr_wdata;
            sfd_pkg::CSR_CTRL_ONE:  ctrl_one_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   assign s1_advance   = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in  = req_ch.valid ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_ch.ready ? s1_valid_in : s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_ch.rx_byte;
      end
   end

   assign len_full = count_ff - sfd_pkg::COUNT_WIDTH'(1);

   // one-pass frame state update
   always_comb begin
      state_in      = state_ff;
      control_in    = control_ff;
      seq_in        = seq_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      xor_in        = xor_ff;
      count_in      = count_ff;
      res_valid     = 1'b0;
      res_kind      = sfd_pkg::KIND_PAYLOAD;
      res_byte      = '0;
      res_seq       = 1'b0;
      res_len       = '0;
      take          = 1'b0;
      take_byte     = s1_byte_ff;

      case (state_ff)
         sfd_pkg::ST_ADDR: begin
            if (s1_byte_ff == address_ff) begin
               state_in = sfd_pkg::ST_CTRL;
            end else if (s1_byte_ff == sfd_pkg::FLAG_BYTE) begin
               state_in = sfd_pkg::ST_ADDR;
            end else begin
               state_in = sfd_pkg::ST_WAIT;
            end
         end
         sfd_pkg::ST_CTRL: begin
            if (s1_byte_ff == ctrl_zero_ff) begin
               seq_in     = 1'b1;
               control_in = s1_byte_ff;
               state_in   = sfd_pkg::ST_HCHK;
            end else if (s1_byte_ff == ctrl_one_ff) begin
               seq_in     = 1'b0;
               control_in = s1_byte_ff;
               state_in   = sfd_pkg::ST_HCHK;
            end else if (s1_byte_ff == sfd_pkg::FLAG_BYTE) begin
               state_in = sfd_pkg::ST_ADDR;
            end else begin
               state_in = sfd_pkg::ST_WAIT;
            end
         end
         sfd_pkg::ST_HCHK: begin
            if (s1_byte_ff == (address_ff ^ control_ff)) begin
               state_in      = sfd_pkg::ST_DATA;
               held_valid_in = 1'b0;
               held_in       = '0;
               xor_in        = '0;
               count_in      = '0;
            end else begin
               state_in = sfd_pkg::ST_WAIT;
            end
         end
         sfd_pkg::ST_DATA: begin
            if (s1_byte_ff == sfd_pkg::FLAG_BYTE) begin
               state_in      = sfd_pkg::ST_WAIT;
               held_valid_in = 1'b0;
               res_valid     = 1'b1;
               res_seq       = seq_ff;
               if ((count_ff != '0) && (xor_ff == '0)) begin
                  res_kind = sfd_pkg::KIND_GOOD;
                  if (len_full > sfd_pkg::COUNT_WIDTH'(sfd_pkg::LEN_MAX)) begin
                     res_len = sfd_pkg::LEN_MAX;
                  end else begin
                     res_len = sfd_pkg::LEN_WIDTH'(len_full);
                  end
               end else begin
                  res_kind = sfd_pkg::KIND_REJECT;
               end
            end else if (s1_byte_ff == sfd_pkg::ESC_BYTE) begin
               state_in = sfd_pkg::ST_ESC;
            end else begin
               take = 1'b1;
            end
         end
         sfd_pkg::ST_ESC: begin
            if (s1_byte_ff == sfd_pkg::STUFF_FLAG_CODE) begin
               state_in  = sfd_pkg::ST_DATA;
               take      = 1'b1;
               take_byte = sfd_pkg::FLAG_BYTE;
            end else if (s1_byte_ff == sfd_pkg::ESC_ESC) begin
               state_in  = sfd_pkg::ST_DATA;
               take      = 1'b1;
               take_byte = sfd_pkg::ESC_BYTE;
            end else begin
               state_in      = sfd_pkg::ST_WAIT;
               held_valid_in = 1'b0;
               res_valid     = 1'b1;
               res_kind      = sfd_pkg::KIND_ESC_ERR;
               res_seq       = seq_ff;
            end
         end
         default: begin
            state_in = (s1_byte_ff == sfd_pkg::FLAG_BYTE) ? sfd_pkg::ST_ADDR
                                                          : sfd_pkg::ST_WAIT;
         end
      endcase

      // data byte goes through the one-byte hold so the check byte never leaves
      if (take) begin
         if (held_valid_ff) begin
            res_valid = 1'b1;
            res_kind  = sfd_pkg::KIND_PAYLOAD;
            res_byte  = held_ff;
         end
         held_in       = take_byte;
         held_valid_in = 1'b1;
         xor_in        = xor_ff ^ take_byte;
         if (count_ff != '1) begin
            count_in = count_ff + sfd_pkg::COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfd_pkg::ST_WAIT;
         control_ff    <= '0;
         seq_ff        <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         xor_ff        <= '0;
         count_ff      <= '0;
      end else if (s1_advance) begin
         state_ff      <= state_in;
         control_ff    <= control_in;
         seq_ff        <= seq_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         xor_ff        <= xor_in;
         count_ff      <= count_in;
      end
   end

   // result register
   assign load_out     = s1_advance && res_valid;
   assign out_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff <= res_kind;
         out_byte_ff <= res_byte;
         out_seq_ff  <= res_seq;
         out_len_ff  <= res_len;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_kind  = out_kind_ff;
   assign rsp_ch.payload_byte = out_byte_ff;
   assign rsp_ch.next_seq     = out_seq_ff;
   assign rsp_ch.frame_length = out_len_ff;

`ifndef ASSERT_OFF
   // a verdict or escape error ends the frame and drops the held byte
   a_verdict_ends_frame: assert property (@(posedge clock) disable iff (reset)
      load_out && (res_kind != sfd_pkg::KIND_PAYLOAD)
      |=> (state_ff == sfd_pkg::ST_WAIT) && !held_valid_ff)
      else $error("frame not closed after verdict");

   // a payload request only leaves while a byte was held
   a_payload_needs_hold: assert property (@(posedge clock) disable iff (reset)
      load_out && (res_kind == sfd_pkg::KIND_PAYLOAD) |-> held_valid_ff && take)
      else $error("payload request without held byte");

   // input stalls only behind a stalled full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && out_valid_ff && !rsp_ch.ready)
      else $error("input stalled without cause");

   // a good verdict always follows at least one counted data byte
   a_good_has_bytes: assert property (@(posedge clock) disable iff (reset)
      load_out && (res_kind == sfd_pkg::KIND_GOOD) |-> (count_ff != '0) && (xor_ff == '0))
      else $error("good verdict on empty or failed frame");
`endif

endmodule
